### src/combinatorial_count_unit_macros.svh
// Assertion macros for the combinatorial count unit checker.
// Expects clk and arst_n in the scope of each use.
`ifndef COMBINATORIAL_COUNT_UNIT_MACROS_SVH
`define COMBINATORIAL_COUNT_UNIT_MACROS_SVH

// same-cycle implication
`define CCU_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define CCU_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### src/ccu_pkg.sv
// Shared types and constants of the combinatorial count unit.
// No dependencies.
package ccu_pkg;

	localparam int unsigned WORD_BITS     = 32;
	localparam int unsigned ROW_DEPTH_DEF = 32;

	typedef logic [WORD_BITS-1:0] word_t;

	localparam logic [1:0] CMD_POWER     = 2'd0;
	localparam logic [1:0] CMD_ARRANGE   = 2'd1;
	localparam logic [1:0] CMD_FACTORIAL = 2'd2;
	localparam logic [1:0] CMD_BINOMIAL  = 2'd3;

	typedef struct packed {
		logic [1:0] command;
		word_t      first_operand;
		word_t      second_operand;
	} job_t;

	typedef struct packed {
		word_t count_value;
		logic  overflow;
	} count_t;

	typedef struct packed {
		logic  load;
		logic  step;
		word_t load_value;
		word_t factor;
	} mul_ctl_t;

	typedef struct packed {
		word_t acc;
		logic  ovf;
	} mul_sts_t;

endpackage

### src/ccu_mul_acc.sv
// Multiply accumulator: acc <= acc * factor per step, overflow flag on the high half.
// Depends on ccu_pkg.
module ccu_mul_acc (
	input  logic              clk,
	input  logic              arst_n,
	input  ccu_pkg::mul_ctl_t ctl,
	output ccu_pkg::mul_sts_t sts
);

	ccu_pkg::word_t                   acc_q;
	logic                             ovf_q;
	logic [2*ccu_pkg::WORD_BITS-1:0]  prod;

	assign prod = (2*ccu_pkg::WORD_BITS)'(acc_q) * (2*ccu_pkg::WORD_BITS)'(ctl.factor);

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			acc_q <= ctl.load_value;
		end else if (ctl.step) begin
			acc_q <= prod[ccu_pkg::WORD_BITS-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ovf_q <= 1'b0;
		end else if (ctl.load) begin
			ovf_q <= 1'b0;
		end else if (ctl.step) begin
			ovf_q <= |prod[2*ccu_pkg::WORD_BITS-1:ccu_pkg::WORD_BITS];
		end
	end

	assign sts.acc = acc_q;
	assign sts.ovf = ovf_q;

endmodule

### src/ccu_row_mem.sv
// Pascal-row store: one write port, one read port, registered read data.
// Depends on ccu_pkg.
module ccu_row_mem #(
	parameter int unsigned ROW_DEPTH = ccu_pkg::ROW_DEPTH_DEF,
	localparam int unsigned AW = $clog2(ROW_DEPTH)
) (
	input  logic           clk,
	input  logic           we,
	input  logic [AW-1:0]  waddr,
	input  ccu_pkg::word_t wdata,
	input  logic [AW-1:0]  raddr,
	output ccu_pkg::word_t rdata
);

	ccu_pkg::word_t mem [ROW_DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

### src/ccu_seq.sv
// Sequencer: decodes a job, runs the multiply loop or the Pascal-row sweep.
// Depends on ccu_pkg; drives ccu_mul_acc and ccu_row_mem.
module ccu_seq #(
	parameter int unsigned ROW_DEPTH = ccu_pkg::ROW_DEPTH_DEF,
	localparam int unsigned AW = $clog2(ROW_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              job_valid,
	output logic              job_ready,
	input  ccu_pkg::job_t     job,
	output logic              res_valid,
	input  logic              res_ready,
	output ccu_pkg::count_t   res,
	output ccu_pkg::mul_ctl_t mul_ctl,
	input  ccu_pkg::mul_sts_t mul_sts,
	output logic              mem_we,
	output logic [AW-1:0]     mem_waddr,
	output ccu_pkg::word_t    mem_wdata,
	output logic [AW-1:0]     mem_raddr,
	input  ccu_pkg::word_t    mem_rdata
);

	localparam int unsigned W = ccu_pkg::WORD_BITS;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_DECODE = 3'd1;
	localparam logic [2:0] ST_BSET   = 3'd2;
	localparam logic [2:0] ST_MUL    = 3'd3;
	localparam logic [2:0] ST_BFILL  = 3'd4;
	localparam logic [2:0] ST_BACC   = 3'd5;
	localparam logic [2:0] ST_DONE   = 3'd6;

	logic [2:0]     state_q, state_d;
	logic [1:0]     cmd_q, cmd_d;
	ccu_pkg::word_t n_q, n_d, k_q, k_d;
	ccu_pkg::word_t cnt_q, cnt_d, fac_q, fac_d, prev_q, prev_d, val_q, val_d;
	logic           inc_q, inc_d, ovf_q, ovf_d;
	logic [AW-1:0]  kk_q, kk_d, j_q, j_d;
	logic [W:0]     n_minus_k;
	logic [W:0]     sum;

	assign n_minus_k = {1'b0, n_q} - {1'b0, k_q};
	assign sum       = {1'b0, prev_q} + {1'b0, mem_rdata};

	always_comb begin
		state_d   = state_q;
		cmd_d     = cmd_q;
		n_d       = n_q;
		k_d       = k_q;
		cnt_d     = cnt_q;
		fac_d     = fac_q;
		inc_d     = inc_q;
		prev_d    = prev_q;
		val_d     = val_q;
		ovf_d     = ovf_q;
		kk_d      = kk_q;
		j_d       = j_q;
		mul_ctl   = '0;
		mul_ctl.factor = fac_q;
		mem_we    = 1'b0;
		mem_waddr = j_q;
		mem_wdata = sum[W-1:0];
		mem_raddr = AW'(1);
		job_ready = (state_q == ST_IDLE);
		res_valid = (state_q == ST_DONE);

		case (state_q)
			ST_IDLE: begin
				if (job_valid) begin
					cmd_d   = job.command;
					n_d     = job.first_operand;
					k_d     = job.second_operand;
					state_d = ST_DECODE;
				end
			end
			ST_DECODE: begin
				case (cmd_q)
					ccu_pkg::CMD_POWER: begin
						if (k_q == '0) begin
							val_d = W'(1); ovf_d = 1'b0; state_d = ST_DONE;
						end else if (n_q <= W'(1)) begin
							val_d = n_q; ovf_d = 1'b0; state_d = ST_DONE;
						end else begin
							mul_ctl.load       = 1'b1;
							mul_ctl.load_value = W'(1);
							fac_d   = n_q;
							cnt_d   = k_q;
							inc_d   = 1'b0;
							state_d = ST_MUL;
						end
					end
					ccu_pkg::CMD_ARRANGE: begin
						if (n_minus_k[W]) begin
							val_d = '0; ovf_d = 1'b0; state_d = ST_DONE;
						end else if (k_q == '0) begin
							val_d = W'(1); ovf_d = 1'b0; state_d = ST_DONE;
						end else begin
							mul_ctl.load       = 1'b1;
							mul_ctl.load_value = n_minus_k[W-1:0] + W'(1);
							fac_d   = n_minus_k[W-1:0] + W'(2);
							cnt_d   = k_q - W'(1);
							inc_d   = 1'b1;
							state_d = ST_MUL;
						end
					end
					ccu_pkg::CMD_FACTORIAL: begin
						mul_ctl.load       = 1'b1;
						mul_ctl.load_value = W'(1);
						fac_d   = W'(1);
						cnt_d   = n_q;
						inc_d   = 1'b1;
						state_d = ST_MUL;
					end
					ccu_pkg::CMD_BINOMIAL: begin
						if (n_minus_k[W]) begin
							val_d = '0; ovf_d = 1'b0; state_d = ST_DONE;
						end else begin
							cnt_d   = (k_q > n_minus_k[W-1:0]) ? n_minus_k[W-1:0] : k_q;
							state_d = ST_BSET;
						end
					end
					default: begin
						state_d = ST_IDLE;
					end
				endcase
			end
			ST_BSET: begin
				if (cnt_q == '0) begin
					val_d = W'(1); ovf_d = 1'b0; state_d = ST_DONE;
				end else if (cnt_q == W'(1)) begin
					val_d = n_q; ovf_d = 1'b0; state_d = ST_DONE;
				end else if (cnt_q >= W'(ROW_DEPTH)) begin
					val_d = '0; ovf_d = 1'b1; state_d = ST_DONE;
				end else begin
					kk_d    = cnt_q[AW-1:0];
					cnt_d   = n_q - cnt_q;
					j_d     = AW'(1);
					state_d = ST_BFILL;
				end
			end
			ST_BFILL: begin
				mem_we    = 1'b1;
				mem_wdata = W'(1);
				if (j_q == kk_q) begin
					j_d     = AW'(1);
					prev_d  = W'(1);
					state_d = ST_BACC;
				end else begin
					j_d = j_q + AW'(1);
				end
			end
			ST_BACC: begin
				if (sum[W]) begin
					val_d = '0; ovf_d = 1'b1; state_d = ST_DONE;
				end else begin
					mem_we = 1'b1;
					prev_d = sum[W-1:0];
					if (j_q == kk_q) begin
						if (cnt_q == W'(1)) begin
							val_d = sum[W-1:0]; ovf_d = 1'b0; state_d = ST_DONE;
						end else begin
							cnt_d  = cnt_q - W'(1);
							j_d    = AW'(1);
							prev_d = W'(1);
						end
					end else begin
						j_d       = j_q + AW'(1);
						mem_raddr = j_q + AW'(1);
					end
				end
			end
			ST_MUL: begin
				if (mul_sts.ovf) begin
					val_d = '0; ovf_d = 1'b1; state_d = ST_DONE;
				end else if (cnt_q == '0) begin
					val_d = mul_sts.acc; ovf_d = 1'b0; state_d = ST_DONE;
				end else begin
					mul_ctl.step = 1'b1;
					cnt_d = cnt_q - W'(1);
					if (inc_q) begin
						fac_d = fac_q + W'(1);
					end
				end
			end
			ST_DONE: begin
				if (res_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		cmd_q  <= cmd_d;
		n_q    <= n_d;
		k_q    <= k_d;
		cnt_q  <= cnt_d;
		fac_q  <= fac_d;
		inc_q  <= inc_d;
		prev_q <= prev_d;
		val_q  <= val_d;
		ovf_q  <= ovf_d;
		kk_q   <= kk_d;
		j_q    <= j_d;
	end

	assign res.count_value = val_q;
	assign res.overflow    = ovf_q;

endmodule

### src/combinatorial_count_unit.sv
// Top level of the combinatorial count unit: sequencer, multiply unit, row store,
// output register. Depends on ccu_pkg, ccu_seq, ccu_mul_acc, ccu_row_mem.
//
//  channel | handshake                 | payload
//  job     | job_valid / job_ready     | job   (ccu_pkg::job_t)
//  count   | count_valid / count_ready | count (ccu_pkg::count_t)
//
// One job at a time; a count settled at decode goes straight to the done state.
// Power, arrangements and factorial: one multiply per cycle; overflow ends the loop early.
// Binomial with r = min(k, n-k): one row entry per cycle through the read and write ports
// of the row store; r <= 1 or a row too deep settles without the row sweep.
// Reset clears control only; a waiting result does not block the next job transfer.
module combinatorial_count_unit #(
	parameter int unsigned ROW_DEPTH = ccu_pkg::ROW_DEPTH_DEF
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            job_valid,
	output logic            job_ready,
	input  ccu_pkg::job_t   job,
	output logic            count_valid,
	input  logic            count_ready,
	output ccu_pkg::count_t count
);

	localparam int unsigned AW = $clog2(ROW_DEPTH);

	ccu_pkg::mul_ctl_t mul_ctl;
	ccu_pkg::mul_sts_t mul_sts;
	ccu_pkg::count_t   res;
	ccu_pkg::count_t   count_q;
	logic              res_valid, res_ready, count_valid_q;
	logic              mem_we;
	logic [AW-1:0]     mem_waddr, mem_raddr;
	ccu_pkg::word_t    mem_wdata, mem_rdata;

	ccu_seq #(.ROW_DEPTH(ROW_DEPTH)) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.job_valid (job_valid),
		.job_ready (job_ready),
		.job       (job),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mul_ctl   (mul_ctl),
		.mul_sts   (mul_sts),
		.mem_we    (mem_we),
		.mem_waddr (mem_waddr),
		.mem_wdata (mem_wdata),
		.mem_raddr (mem_raddr),
		.mem_rdata (mem_rdata)
	);

	ccu_mul_acc u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mul_ctl),
		.sts    (mul_sts)
	);

	ccu_row_mem #(.ROW_DEPTH(ROW_DEPTH)) u_row (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	assign res_ready = !count_valid_q || count_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			count_valid_q <= 1'b1;
		end else if (count_ready) begin
			count_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			count_q <= res;
		end
	end

	assign count_valid = count_valid_q;
	assign count       = count_q;

endmodule

### src/ccu_checker.sv
// Port-level checker for combinatorial_count_unit, bound to the top level.
// Depends on ccu_pkg and combinatorial_count_unit_macros.svh.
`include "combinatorial_count_unit_macros.svh"

module ccu_checker (
	input logic            clk,
	input logic            arst_n,
	input logic            job_valid,
	input logic            job_ready,
	input ccu_pkg::job_t   job,
	input logic            count_valid,
	input logic            count_ready,
	input ccu_pkg::count_t count
);

	`CCU_ASSERT_NEXT(a_count_hold, count_valid && !count_ready, count_valid && $stable(count), "count changed while stalled")
	`CCU_ASSERT_NOW(a_ovf_zero, count_valid && count.overflow, count.count_value == '0, "overflow with nonzero count")
	`CCU_ASSERT_NEXT(a_one_job, job_valid && job_ready, !job_ready, "second job taken while busy")

endmodule

bind combinatorial_count_unit ccu_checker u_ccu_checker (.*);
